FILE: design/http_request_line_parser_top_defines.svh
// Assertion macros for the HTTP request line parser.
// Used by http_request_line_parser_top; no other dependencies.
`ifndef HTTP_REQUEST_LINE_PARSER_TOP_DEFINES_SVH
`define HTTP_REQUEST_LINE_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HRLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrlp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HRLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrlp assertion failed");

`endif

FILE: design/hrlp_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and match tables for the HTTP request line parser.
// No dependencies.
package hrlp_pkg;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_EMPTY       = 3'd1;
  localparam logic [2:0] ST_MALFORMED   = 3'd2;
  localparam logic [2:0] ST_BAD_METHOD  = 3'd3;
  localparam logic [2:0] ST_BAD_VERSION = 3'd4;
  localparam logic [2:0] ST_BAD_URI     = 3'd5;

  localparam logic [1:0] METH_GET    = 2'd0;
  localparam logic [1:0] METH_POST   = 2'd1;
  localparam logic [1:0] METH_DELETE = 2'd2;
  localparam logic [1:0] METH_NONE   = 2'd3;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [3:0] LEN_GET     = 4'd3;
  localparam logic [3:0] LEN_POST    = 4'd4;
  localparam logic [3:0] LEN_DELETE  = 4'd6;
  localparam logic [3:0] LEN_VERSION = 4'd8;
  localparam logic [3:0] POS_SAT     = 4'd9;

  localparam logic [63:0] VER_TXT = "HTTP/1.1";

  typedef struct packed {
    logic [1:0] token_count;
    logic       inside_token;
    logic [3:0] char_position;
    logic [2:0] method_candidates;  // bit0 GET, bit1 POST, bit2 DELETE
    logic       version_matches;
    logic       uri_starts_slash;
    logic       query_seen;
    logic       seen_byte;
  } state_t;

  localparam state_t STATE_RESET = '{
    token_count:       2'd0,
    inside_token:      1'b0,
    char_position:     4'd0,
    method_candidates: 3'b111,
    version_matches:   1'b1,
    uri_starts_slash:  1'b0,
    query_seen:        1'b0,
    seen_byte:         1'b0
  };

  typedef struct packed {
    logic       uri_valid;
    logic [7:0] uri_char;
    logic       in_query;
    logic       done_res;
    logic [2:0] status;
    logic [1:0] method_code;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [7:0] get_char(input logic [3:0] p);
    logic [7:0] r;
    case (p)
      4'd0:    r = "G";
      4'd1:    r = "E";
      4'd2:    r = "T";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] post_char(input logic [3:0] p);
    logic [7:0] r;
    case (p)
      4'd0:    r = "P";
      4'd1:    r = "O";
      4'd2:    r = "S";
      4'd3:    r = "T";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] delete_char(input logic [3:0] p);
    logic [7:0] r;
    case (p)
      4'd0:    r = "D";
      4'd1:    r = "E";
      4'd2:    r = "L";
      4'd3:    r = "E";
      4'd4:    r = "T";
      4'd5:    r = "E";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ver_char(input logic [2:0] p);
    return VER_TXT[(6'd56 - {p, 3'b000}) +: 8];
  endfunction

  // End a token: keep only the method matches of the right length and
  // drop the version match if the third token is not exactly eight bytes.
  function automatic state_t close_token(input state_t s);
    state_t r;
    r = s;
    if (s.inside_token) begin
      if (s.token_count == 2'd1) begin
        r.method_candidates = s.method_candidates &
            {s.char_position == LEN_DELETE, s.char_position == LEN_POST,
             s.char_position == LEN_GET};
      end else if (s.token_count == 2'd3) begin
        if (s.char_position != LEN_VERSION) r.version_matches = 1'b0;
      end
      r.inside_token = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: design/hrlp_engine.sv
`timescale 1ns / 1ps
// Per-byte tokenizer and matcher: line state registers plus the step logic.
// Depends on hrlp_pkg.
module hrlp_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        ch,
  input  logic              has_char,
  input  logic              last,
  output hrlp_pkg::result_t res
);
  import hrlp_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_t     s;
    logic [3:0] p;
    s   = state_r;
    p   = 4'd0;
    res = '0;
    if (has_char) begin
      s.seen_byte = 1'b1;
      if (is_space(ch)) begin
        s = close_token(s);
      end else if (s.inside_token || (s.token_count != 2'd3)) begin
        if (!s.inside_token) begin
          s.token_count   = s.token_count + 2'd1;
          s.inside_token  = 1'b1;
          s.char_position = 4'd0;
        end
        p = s.char_position;
        if (s.token_count == 2'd1) begin
          if (!((p < LEN_GET) && (ch == get_char(p))))
            s.method_candidates[0] = 1'b0;
          if (!((p < LEN_POST) && (ch == post_char(p))))
            s.method_candidates[1] = 1'b0;
          if (!((p < LEN_DELETE) && (ch == delete_char(p))))
            s.method_candidates[2] = 1'b0;
        end else if (s.token_count == 2'd2) begin
          if (p == 4'd0) s.uri_starts_slash = (ch == CH_SLASH);
          // first '?' splits path from query and is dropped
          if ((ch == CH_QMARK) && !s.query_seen) begin
            s.query_seen = 1'b1;
          end else begin
            res.uri_valid = 1'b1;
            res.uri_char  = ch;
            res.in_query  = s.query_seen;
          end
        end else begin
          if (!((p < LEN_VERSION) && (ch == ver_char(p[2:0]))))
            s.version_matches = 1'b0;
        end
        if (s.char_position < POS_SAT) s.char_position = s.char_position + 4'd1;
      end
    end

    if (last) begin
      s = close_token(s);
      res.done_res    = 1'b1;
      res.method_code = METH_NONE;
      if (!s.seen_byte) begin
        res.status = ST_EMPTY;
      end else if (s.token_count != 2'd3) begin
        res.status = ST_MALFORMED;
      end else if (s.method_candidates == 3'b000) begin
        res.status = ST_BAD_METHOD;
      end else begin
        res.method_code = s.method_candidates[0] ? METH_GET :
                          (s.method_candidates[1] ? METH_POST : METH_DELETE);
        if (!s.version_matches)       res.status = ST_BAD_VERSION;
        else if (!s.uri_starts_slash) res.status = ST_BAD_URI;
        else                          res.status = ST_OK;
      end
      state_nxt = STATE_RESET;
    end else begin
      state_nxt = s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/http_request_line_parser_top.sv
`timescale 1ns / 1ps
// HTTP request line parser, one byte per transfer in, one result per transfer
// out. A transfer is taken every cycle while the output is not stalled; two
// register stages (input, result). Bytes of the URI stream out tagged path or
// query; the result of the item marked last carries the status and method
// code, after which the parser is back in its reset state.
// Depends on hrlp_pkg, hrlp_engine and http_request_line_parser_top_defines.svh.
`include "http_request_line_parser_top_defines.svh"

module http_request_line_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  // input channel: one byte of the request line per transfer
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_has_char,
  input  logic       in_last,
  // result channel: one result per input transfer
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_uri_valid,
  output logic [7:0] out_uri_char,
  output logic       out_in_query,
  output logic       out_done_res,
  output logic [2:0] out_status,
  output logic [1:0] out_method_code
);
  import hrlp_pkg::*;

  // Input stage holds one accepted byte until the result stage can take it.
  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_has_char_r;
  logic       s1_last_r;

  // Result stage: the registered output.
  logic       out_valid_r;
  result_t    out_res_r;

  result_t    step_res;
  logic       out_free;
  logic       s1_fire;
  logic       in_fire;

  // Result register can load when empty or when its transfer completes.
  assign out_free = !out_valid_r || !out_stall;
  // Input stage moves forward and updates line state in the same edge.
  assign s1_fire  = s1_valid_r && out_free;
  // Stall input only when the input stage is full and cannot drain.
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch_r       <= in_ch;
      s1_has_char_r <= in_has_char;
      s1_last_r     <= in_last;
    end
  end

  hrlp_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (s1_fire),
    .ch       (s1_ch_r),
    .has_char (s1_has_char_r),
    .last     (s1_last_r),
    .res      (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Hold the result while stalled; load a new one when the stage frees up.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_uri_valid   = out_res_r.uri_valid;
  assign out_uri_char    = out_res_r.uri_char;
  assign out_in_query    = out_res_r.in_query;
  assign out_done_res    = out_res_r.done_res;
  assign out_status      = out_res_r.status;
  assign out_method_code = out_res_r.method_code;

  // Status and method code stay zero except on the end-of-line result.
  `HRLP_ASSERT_NOW(a_idle_status, clk, rst_n, out_valid_r && !out_res_r.done_res,
      (out_res_r.status == ST_OK) && (out_res_r.method_code == METH_GET))
  // A result without a URI byte carries no byte and no query tag.
  `HRLP_ASSERT_NOW(a_no_uri_zero, clk, rst_n, out_valid_r && !out_res_r.uri_valid,
      (out_res_r.uri_char == 8'h00) && !out_res_r.in_query)
  // A good line always names a method.
  `HRLP_ASSERT_NOW(a_ok_has_method, clk, rst_n,
      out_valid_r && out_res_r.done_res && (out_res_r.status == ST_OK),
      out_res_r.method_code != METH_NONE)
  // A stall on the input side means the input stage is still occupied next.
  `HRLP_ASSERT_NEXT(a_stall_holds, clk, rst_n, in_stall && in_valid, s1_valid_r)

endmodule

FILE: tb/sv/hrlp_checker.sv
`timescale 1ns / 1ps
// Checker for the HTTP request line parser: watches both channels, predicts each result.
// Depends on hrlp_pkg for the status and method codes and the result layout.
module hrlp_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_has_char,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_uri_valid,
  input  logic [7:0] out_uri_char,
  input  logic       out_in_query,
  input  logic       out_done_res,
  input  logic [2:0] out_status,
  input  logic [1:0] out_method_code,
  output int         fail_count,
  output int         exp_pending,
  output int         lines_seen,
  output int         lines_ok,
  output int         results_seen
);
  import hrlp_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // parse state of the line in progress
  logic [1:0] tok_cnt;
  logic       in_tok;
  logic [3:0] tok_pos;
  logic [2:0] meth_alive;  // bit0 GET, bit1 POST, bit2 DELETE
  logic       ver_alive;
  logic       uri_slash;
  logic       qmark_passed;
  logic       got_byte;

  result_t pending_results[$];
  int      fails;
  int      n_lines;
  int      n_ok;
  int      n_results;

  function automatic string method_name(input int k);
    case (k)
      0:       return "GET";
      1:       return "POST";
      default: return "DELETE";
    endcase
  endfunction

  function automatic logic blank(input logic [7:0] c);
    case (c)
      CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR: return 1'b1;
      default:                                      return 1'b0;
    endcase
  endfunction

  function automatic void clear_line();
    tok_cnt      = '0;
    in_tok       = 1'b0;
    tok_pos      = '0;
    meth_alive   = 3'b111;
    ver_alive    = 1'b1;
    uri_slash    = 1'b0;
    qmark_passed = 1'b0;
    got_byte     = 1'b0;
  endfunction

  // A token ends: the method must have the full length, and so must the version.
  function automatic void finish_token();
    string name;
    if (in_tok) begin
      if (tok_cnt == 2'd1) begin
        for (int k = 0; k < 3; k++) begin
          name = method_name(k);
          if (tok_pos != name.len()) meth_alive[k] = 1'b0;
        end
      end else if (tok_cnt == 2'd3 && tok_pos != 4'd8) begin
        ver_alive = 1'b0;
      end
      in_tok = 1'b0;
    end
  endfunction

  // Advance the parse by one input transfer and return the result it causes.
  function automatic result_t parse_byte(input logic [7:0] c, input logic h, input logic l);
    result_t r;
    string   name;
    string   ver;
    int      p;
    r   = '0;
    ver = "HTTP/1.1";
    if (h) begin
      got_byte = 1'b1;
      if (blank(c)) begin
        finish_token();
      end else if (in_tok || tok_cnt < 2'd3) begin
        if (!in_tok) begin
          tok_cnt = tok_cnt + 2'd1;
          in_tok  = 1'b1;
          tok_pos = '0;
        end
        p = tok_pos;
        case (tok_cnt)
          2'd1: begin
            for (int k = 0; k < 3; k++) begin
              name = method_name(k);
              if (!(p < name.len() && c == name[p])) meth_alive[k] = 1'b0;
            end
          end
          2'd2: begin
            if (p == 0) uri_slash = (c == CH_SLASH);
            // only the first '?' splits path from query and is swallowed
            if (c == CH_QMARK && !qmark_passed) begin
              qmark_passed = 1'b1;
            end else begin
              r.uri_valid = 1'b1;
              r.uri_char  = c;
              r.in_query  = qmark_passed;
            end
          end
          default: begin
            if (!(p < 8 && c == ver[p])) ver_alive = 1'b0;
          end
        endcase
        if (tok_pos < POS_SAT) tok_pos = tok_pos + 4'd1;
      end
    end
    if (l) begin
      finish_token();
      r.done_res    = 1'b1;
      r.method_code = METH_NONE;
      if (!got_byte) begin
        r.status = ST_EMPTY;
      end else if (tok_cnt < 2'd3) begin
        r.status = ST_MALFORMED;
      end else if (meth_alive == 3'b000) begin
        r.status = ST_BAD_METHOD;
      end else begin
        r.method_code = meth_alive[0] ? METH_GET : (meth_alive[1] ? METH_POST : METH_DELETE);
        if (!ver_alive)      r.status = ST_BAD_VERSION;
        else if (!uri_slash) r.status = ST_BAD_URI;
        else                 r.status = ST_OK;
      end
      clear_line();
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      clear_line();
      pending_results.delete();
      fails     = 0;
      n_lines   = 0;
      n_ok      = 0;
      n_results = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_uri_valid, out_uri_char, out_in_query, out_done_res, out_status,
               out_method_code};
        n_results++;
        if (pending_results.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("%0t ERROR: result transfer with nothing expected", $realtime);
        end else begin
          want = pending_results.pop_front();
          if (want.uri_valid != got.uri_valid || want.uri_char != got.uri_char ||
              want.in_query != got.in_query || want.done_res != got.done_res ||
              want.status != got.status || want.method_code != got.method_code) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
              $display("%0t ERROR: result %0d differs", $realtime, n_results);
              $display("  expected uri_valid=%0b uri_char=%02h in_query=%0b done=%0b st=%0d mc=%0d",
                       want.uri_valid, want.uri_char, want.in_query, want.done_res,
                       want.status, want.method_code);
              $display("  actual   uri_valid=%0b uri_char=%02h in_query=%0b done=%0b st=%0d mc=%0d",
                       got.uri_valid, got.uri_char, got.in_query, got.done_res,
                       got.status, got.method_code);
            end
          end
          if (want.done_res) begin
            n_lines++;
            if (want.status == ST_OK) n_ok++;
          end
        end
      end
      if (in_valid && !in_stall)
        pending_results.push_back(parse_byte(in_ch, in_has_char, in_last));
    end
    fail_count   <= fails;
    exp_pending  <= pending_results.size();
    lines_seen   <= n_lines;
    lines_ok     <= n_ok;
    results_seen <= n_results;
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the HTTP request line parser testbench: clock, reset, stimulus and verdict.
// Depends on hrlp_pkg, http_request_line_parser_top and hrlp_checker.
module tb_top;
  import hrlp_pkg::*;

  localparam int ITEMS_PER_PHASE = 550;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 400000;

  // blank bytes that the package does not name
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic [7:0] in_ch       = 8'h00;
  logic       in_has_char = 1'b0;
  logic       in_last     = 1'b0;
  logic       out_stall   = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       out_uri_valid;
  logic [7:0] out_uri_char;
  logic       out_in_query;
  logic       out_done_res;
  logic [2:0] out_status;
  logic [1:0] out_method_code;

  int fail_count;
  int exp_pending;
  int lines_seen;
  int lines_ok;
  int results_seen;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic start_hold     = 1'b0;
  logic hold_off       = 1'b0;
  int   items_sent     = 0;
  int   cycle_count    = 0;

  // bytes of the request line being built
  logic [7:0] line_q[$];

  http_request_line_parser_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_ch           (in_ch),
    .in_has_char     (in_has_char),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_uri_valid   (out_uri_valid),
    .out_uri_char    (out_uri_char),
    .out_in_query    (out_in_query),
    .out_done_res    (out_done_res),
    .out_status      (out_status),
    .out_method_code (out_method_code)
  );

  hrlp_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_ch           (in_ch),
    .in_has_char     (in_has_char),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_uri_valid   (out_uri_valid),
    .out_uri_char    (out_uri_char),
    .out_in_query    (out_in_query),
    .out_done_res    (out_done_res),
    .out_status      (out_status),
    .out_method_code (out_method_code),
    .fail_count      (fail_count),
    .exp_pending     (exp_pending),
    .lines_seen      (lines_seen),
    .lines_ok        (lines_ok),
    .results_seen    (results_seen)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Stop a hung run: anything left at the limit counts as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count,
               exp_pending);
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: stall at random, or solidly while a hold-off runs.
  always @(posedge clk) begin
    out_stall <= rst_n && (hold_off || ($urandom_range(99) < recv_stall_pct));
  end

  // One long hold-off: keep the result side stalled for a fixed stretch so the
  // parser fills up and pushes back on its input.
  initial begin
    do @(posedge clk); while (!start_hold);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Offer one transfer after a random number of idle cycles and hold it until taken.
  task automatic send_item(input logic [7:0] c, input logic h, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_ch       <= c;
    in_has_char <= h;
    in_last     <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_VT;
      4:       return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // Any byte that does not split tokens, weighted toward printable text.
  function automatic logic [7:0] pick_word();
    case ($urandom_range(9))
      0:       return 8'($urandom_range(8'h08, 8'h00));
      1:       return 8'($urandom_range(8'h1F, 8'h0E));
      2, 3:    return 8'($urandom_range(8'hFF, 8'h80));
      default: return 8'($urandom_range(8'h7F, 8'h21));
    endcase
  endfunction

  function automatic string pick_method();
    case ($urandom_range(2))
      0:       return "GET";
      1:       return "POST";
      default: return "DELETE";
    endcase
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic push_gap();
    repeat ($urandom_range(3, 1)) line_q.push_back(pick_blank());
  endtask

  // Push a token that is either the expected text or a near miss of it:
  // cut short, run long (at times past the position counter's saturation), one byte
  // off, or plain noise.
  task automatic push_token(input string base, input int good_pct);
    int cut;
    int spot;
    if ($urandom_range(99) < good_pct) begin
      push_text(base);
      return;
    end
    case ($urandom_range(3))
      0: begin
        cut = $urandom_range(base.len() - 1, 1);
        for (int i = 0; i < cut; i++) line_q.push_back(base[i]);
      end
      1: begin
        push_text(base);
        repeat ($urandom_range(14, 1)) line_q.push_back(pick_word());
      end
      2: begin
        spot = $urandom_range(base.len() - 1);
        for (int i = 0; i < base.len(); i++)
          line_q.push_back(i == spot ? pick_word() : 8'(base[i]));
      end
      default: begin
        repeat ($urandom_range(20, 1)) line_q.push_back(pick_word());
      end
    endcase
  endtask

  // URI: mostly rooted at '/', with a sprinkling of '?' to split path and query.
  task automatic push_uri();
    int r;
    r = $urandom_range(99);
    if (r < 85)      line_q.push_back(CH_SLASH);
    else if (r < 90) line_q.push_back(CH_QMARK);
    else             line_q.push_back(pick_word());
    repeat ($urandom_range(12)) begin
      if ($urandom_range(99) < 12) line_q.push_back(CH_QMARK);
      else                         line_q.push_back(pick_word());
    end
  endtask

  // Build one random request line: mostly three tokens, each usually well-formed,
  // with random content; the rest empty, blank-only, short, or carrying extra tokens.
  task automatic build_line();
    int kind;
    int ntok;
    kind = $urandom_range(99);
    line_q.delete();
    if (kind < 3) return;
    if (kind < 6) begin
      repeat ($urandom_range(4, 1)) line_q.push_back(pick_blank());
      return;
    end
    ntok = (kind < 14) ? $urandom_range(2, 1) : 3;
    if ($urandom_range(9) == 0) push_gap();
    push_token(pick_method(), 75);
    if (ntok > 1) begin
      push_gap();
      push_uri();
    end
    if (ntok > 2) begin
      push_gap();
      push_token("HTTP/1.1", 75);
      if ($urandom_range(6) == 0) begin
        push_gap();
        push_token(pick_method(), 0);
      end
    end
    if ($urandom_range(7) == 0) push_gap();
  endtask

  // Send the built line. Mark the end on the final byte, or on a separate
  // byte-less transfer when sep_last is set or the line is empty.
  task automatic send_line(input bit sep_last);
    int n;
    n = line_q.size();
    foreach (line_q[i]) begin
      if ($urandom_range(39) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(line_q[i], 1'b1, !sep_last && i == n - 1);
    end
    if (sep_last || n == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Run random lines under one idling setting; with squeeze, also start the
  // long hold-off and pause the sender halfway until everything has drained.
  task automatic run_phase(input int idle_pct, input int stall_pct, input int quota,
                           input bit squeeze);
    int  stop_at;
    bit  paused;
    stop_at        = items_sent + quota;
    paused         = 1'b0;
    send_idle_pct  = idle_pct;
    recv_stall_pct <= stall_pct;
    if (squeeze) start_hold <= 1'b1;
    while (items_sent < stop_at) begin
      if (squeeze && !paused && items_sent >= stop_at - quota / 2) begin
        paused = 1'b1;
        wait_results();
      end
      build_line();
      send_line($urandom_range(3) == 0);
    end
  endtask

  initial begin
    // hold reset, then release it for good
    repeat (8) @(posedge clk);
    rst_n          <= 1'b1;
    send_idle_pct  = 25;
    recv_stall_pct <= 83;

    // empty line, then a line of nothing but blanks
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(CH_FF, 1'b1, 1'b0);
    send_item(CH_CR, 1'b1, 1'b1);
    // byte-less filler between lines
    send_item(8'h00, 1'b0, 1'b0);
    // DELETE with zero and all-ones URI bytes, a second '?' that stays in the
    // query, and a fourth token that must be ignored
    line_q.delete();
    push_text("DELETE");
    line_q.push_back(CH_SPACE);
    line_q.push_back(CH_SLASH);
    line_q.push_back(8'h00);
    line_q.push_back(CH_QMARK);
    line_q.push_back(8'hFF);
    line_q.push_back(CH_QMARK);
    line_q.push_back(CH_TAB);
    push_text("HTTP/1.1");
    line_q.push_back(CH_SPACE);
    push_text("z");
    send_line(1'b0);

    run_phase(25, 83, ITEMS_PER_PHASE, 1'b0);
    run_phase(83, 25, ITEMS_PER_PHASE, 1'b0);
    run_phase(0, 0, ITEMS_PER_PHASE, 1'b1);

    // drain, then give any stray result time to show up
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d request lines (%0d parsed clean) from %0d input transfers;",
             lines_seen, lines_ok, items_sent);
    $display("%0d results compared across sender gaps, receiver stalls and a hold-off.",
             results_seen);
    if (fail_count == 0 && exp_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
